// ----- rtl/core/sfa_pkg.sv -----
// Package for the statistics fragment aggregator.
// Holds the item types, the configuration register map and a shared saturating-add helper.
// No dependencies.
package sfa_pkg;

	localparam int unsigned ADDR_W = 4;

	localparam logic [1:0] REG_TARGET_PARTITION = 2'd0;
	localparam logic [1:0] REG_EXPECTED_FORMAT  = 2'd1;
	localparam logic [1:0] REG_STORE_CORRUPT    = 2'd2;

	localparam logic [31:0] EXPECTED_FORMAT_RESET = 32'd1;

	typedef enum logic {
		KIND_FRAGMENT = 1'b0,
		KIND_FINISH   = 1'b1
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] source_id;
		logic [23:0] partition;
		logic [63:0] rows;
		logic [63:0] puts;
		logic [63:0] deletes;
		logic [63:0] distinct_values;
		logic [63:0] valid_from_low;
		logic [63:0] valid_from_high;
		logic [63:0] commit_seq_low;
		logic [63:0] commit_seq_high;
		logic [31:0] format_tag;
	} frag_t;

	typedef struct packed {
		logic [63:0] sum_rows;
		logic [63:0] sum_puts;
		logic [63:0] sum_deletes;
		logic [63:0] sum_distinct;
		logic [63:0] agg_valid_from_low;
		logic [63:0] agg_valid_from_high;
		logic [63:0] agg_commit_seq_low;
		logic [63:0] agg_commit_seq_high;
		logic        complete;
	} result_t;

	typedef struct packed {
		logic [23:0] target_partition;
		logic [31:0] expected_format;
		logic        store_corrupt;
	} cfg_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

// ----- rtl/core/statistics_fragment_aggregator_unit.sv -----
// Top level of the statistics fragment aggregator.
// Instantiates sfa_regs, sfa_check and sfa_merge; uses sfa_pkg.
//
// Each item is registered at the input, then validated and folded into the running
// aggregate, so the block takes one item every cycle while frag_stall is low.
// A finish item's result passes through the input register and then the single result
// register, where it is held until taken; that register is the only thing that can stall
// the input, and only a finish item waiting behind an untaken result does so.
module statistics_fragment_aggregator_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       frag_valid,
	output logic                       frag_stall,
	input  sfa_pkg::frag_t             frag,
	output logic                       res_valid,
	input  logic                       res_stall,
	output sfa_pkg::result_t           res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfa_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	sfa_pkg::cfg_t    cfg;
	sfa_pkg::frag_t   frag_s1;
	logic             valid_s1;
	logic             frag_ok;
	logic             advance_s1;
	logic             step;
	logic             load_res;
	sfa_pkg::result_t result;
	sfa_pkg::result_t res_q;
	logic             res_valid_q;

	assign pready     = 1'b1;
	assign advance_s1 = !(valid_s1 && (frag_s1.kind == sfa_pkg::KIND_FINISH) &&
		res_valid_q && res_stall);
	assign frag_stall = !advance_s1;
	assign step       = valid_s1 && advance_s1;
	assign load_res   = step && (frag_s1.kind == sfa_pkg::KIND_FINISH);
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	sfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	sfa_check u_check (
		.frag    (frag_s1),
		.cfg     (cfg),
		.frag_ok (frag_ok)
	);

	sfa_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.frag    (frag_s1),
		.frag_ok (frag_ok),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frag_valid && !frag_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (frag_valid && !frag_stall) begin
			frag_s1 <= frag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= result;
		end
	end

endmodule

// ----- rtl/core/sfa_regs.sv -----
// Configuration registers of the statistics fragment aggregator.
// APB-style write and read port; uses sfa_pkg.
module sfa_regs (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sfa_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output sfa_pkg::cfg_t              cfg
);

	sfa_pkg::cfg_t cfg_q;
	logic [1:0]    reg_index;
	logic          wr_en;

	assign reg_index = paddr[3:2];
	assign wr_en     = psel && penable && pwrite;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_partition <= '0;
			cfg_q.expected_format  <= sfa_pkg::EXPECTED_FORMAT_RESET;
			cfg_q.store_corrupt    <= 1'b0;
		end else if (wr_en) begin
			case (reg_index)
				sfa_pkg::REG_TARGET_PARTITION: cfg_q.target_partition <= pwdata[23:0];
				sfa_pkg::REG_EXPECTED_FORMAT:  cfg_q.expected_format  <= pwdata;
				sfa_pkg::REG_STORE_CORRUPT:    cfg_q.store_corrupt    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index)
			sfa_pkg::REG_TARGET_PARTITION: prdata = {8'd0, cfg_q.target_partition};
			sfa_pkg::REG_EXPECTED_FORMAT:  prdata = cfg_q.expected_format;
			sfa_pkg::REG_STORE_CORRUPT:    prdata = {31'd0, cfg_q.store_corrupt};
			default:                       prdata = '0;
		endcase
	end

endmodule

// ----- rtl/core/sfa_check.sv -----
// Fragment validation of the statistics fragment aggregator.
// Pure combinational checks of one fragment; uses sfa_pkg.
module sfa_check (
	input  sfa_pkg::frag_t frag,
	input  sfa_pkg::cfg_t  cfg,
	output logic           frag_ok
);

	logic [63:0] pd_sum;
	logic        base_ok;
	logic        range_ok;

	assign pd_sum = frag.puts + frag.deletes;

	assign base_ok = (frag.source_id != '0) &&
		(frag.partition == cfg.target_partition) &&
		(frag.format_tag == cfg.expected_format) &&
		(frag.puts <= frag.rows) && (frag.deletes <= frag.rows) &&
		(pd_sum == frag.rows) && (frag.distinct_values <= frag.puts);

	assign range_ok = (frag.rows == '0) ||
		((frag.valid_from_low <= frag.valid_from_high) &&
		 (frag.commit_seq_low <= frag.commit_seq_high));

	assign frag_ok = base_ok && range_ok;

endmodule

// ----- rtl/core/sfa_merge.sv -----
// Running aggregate of the statistics fragment aggregator.
// Holds the totals and ranges, merges valid fragments until the first invalid one
// and forms the finish result, which is zero while store_corrupt is set. Uses sfa_pkg.
module sfa_merge (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  sfa_pkg::frag_t   frag,
	input  logic             frag_ok,
	input  sfa_pkg::cfg_t    cfg,
	output sfa_pkg::result_t result
);

	logic [63:0] total_rows_q;
	logic [63:0] total_puts_q;
	logic [63:0] total_deletes_q;
	logic [63:0] total_distinct_q;
	logic [63:0] vf_low_q;
	logic [63:0] vf_high_q;
	logic [63:0] cs_low_q;
	logic [63:0] cs_high_q;
	logic        stopped_q;
	logic        first;
	logic        is_finish;

	assign is_finish = (frag.kind == sfa_pkg::KIND_FINISH);
	assign first     = (total_rows_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_rows_q     <= '0;
			total_puts_q     <= '0;
			total_deletes_q  <= '0;
			total_distinct_q <= '0;
			vf_low_q         <= '0;
			vf_high_q        <= '0;
			cs_low_q         <= '0;
			cs_high_q        <= '0;
			stopped_q        <= 1'b0;
		end else if (step) begin
			if (is_finish) begin
				total_rows_q     <= '0;
				total_puts_q     <= '0;
				total_deletes_q  <= '0;
				total_distinct_q <= '0;
				vf_low_q         <= '0;
				vf_high_q        <= '0;
				cs_low_q         <= '0;
				cs_high_q        <= '0;
				stopped_q        <= 1'b0;
			end else if (!cfg.store_corrupt && !stopped_q) begin
				if (!frag_ok) begin
					stopped_q <= 1'b1;
				end else begin
					if (first || frag.valid_from_low < vf_low_q) begin
						vf_low_q <= frag.valid_from_low;
					end
					if (first || frag.valid_from_high > vf_high_q) begin
						vf_high_q <= frag.valid_from_high;
					end
					if (first || frag.commit_seq_low < cs_low_q) begin
						cs_low_q <= frag.commit_seq_low;
					end
					if (first || frag.commit_seq_high > cs_high_q) begin
						cs_high_q <= frag.commit_seq_high;
					end
					total_rows_q     <= sfa_pkg::sat_add(total_rows_q, frag.rows);
					total_puts_q     <= sfa_pkg::sat_add(total_puts_q, frag.puts);
					total_deletes_q  <= sfa_pkg::sat_add(total_deletes_q, frag.deletes);
					total_distinct_q <= sfa_pkg::sat_add(total_distinct_q, frag.distinct_values);
				end
			end
		end
	end

	always_comb begin
		if (cfg.store_corrupt) begin
			result = '0;
		end else begin
			result.sum_rows            = total_rows_q;
			result.sum_puts            = total_puts_q;
			result.sum_deletes         = total_deletes_q;
			result.sum_distinct        = total_distinct_q;
			result.agg_valid_from_low  = vf_low_q;
			result.agg_valid_from_high = vf_high_q;
			result.agg_commit_seq_low  = cs_low_q;
			result.agg_commit_seq_high = cs_high_q;
			result.complete            = !stopped_q;
		end
	end

endmodule

// ----- rtl/core/sfa_checker.sv -----
// Port-level checks for the statistics fragment aggregator.
// Sees only the top level's ports; bound to statistics_fragment_aggregator_unit.
// Uses sfa_pkg.
module sfa_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             frag_valid,
	input logic             frag_stall,
	input sfa_pkg::frag_t   frag,
	input logic             res_valid,
	input logic             res_stall,
	input sfa_pkg::result_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("Stalled result item changed or dropped.");

	a_res_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |->
			$past(frag_valid && !frag_stall && (frag.kind == sfa_pkg::KIND_FINISH), 2))
		else $error("Result item appeared without a finish item two cycles before.");

	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.sum_puts <= res.sum_rows) && (res.sum_deletes <= res.sum_rows) &&
			(res.sum_distinct <= res.sum_puts))
		else $error("Merged totals break the count rules.");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.sum_rows != '0) |->
			(res.agg_valid_from_low <= res.agg_valid_from_high) &&
			(res.agg_commit_seq_low <= res.agg_commit_seq_high))
		else $error("Merged ranges are out of order.");

endmodule

bind statistics_fragment_aggregator_unit sfa_checker u_sfa_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.frag_valid (frag_valid),
	.frag_stall (frag_stall),
	.frag       (frag),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);
